>>> src/hrfp_pkg.sv
// ----------------------------------------------------------------------------
// hrfp_pkg
// Shared types, constants and commands of the HID report field parser.
// ----------------------------------------------------------------------------
package hrfp_pkg;

  localparam int unsigned MaxFieldsDefault  = 32;
  localparam int unsigned UsageSlotsDefault = 8;
  localparam int unsigned CfgW              = 6;
  localparam int unsigned QueueDepth        = 2;

  // item prefixes
  localparam logic [7:0] PfxLong     = 8'hFE;
  localparam logic [7:0] PfxPage     = 8'h05;
  localparam logic [7:0] PfxLmin1    = 8'h15;
  localparam logic [7:0] PfxLmin2    = 8'h16;
  localparam logic [7:0] PfxLmin4    = 8'h17;
  localparam logic [7:0] PfxLmax1    = 8'h25;
  localparam logic [7:0] PfxLmax2    = 8'h26;
  localparam logic [7:0] PfxLmax4    = 8'h27;
  localparam logic [7:0] PfxSize     = 8'h75;
  localparam logic [7:0] PfxReportId = 8'h85;
  localparam logic [7:0] PfxCount    = 8'h95;
  localparam logic [7:0] PfxUsage    = 8'h09;
  localparam logic [7:0] PfxUmin1    = 8'h19;
  localparam logic [7:0] PfxUmin2    = 8'h1A;
  localparam logic [7:0] PfxUmin4    = 8'h1B;
  localparam logic [7:0] PfxUmax1    = 8'h29;
  localparam logic [7:0] PfxUmax2    = 8'h2A;
  localparam logic [7:0] PfxUmax4    = 8'h2B;
  localparam logic [7:0] PfxInput    = 8'h81;
  localparam logic [7:0] PfxColl     = 8'hA1;
  localparam logic [1:0] SizeCode4   = 2'd3;

  typedef enum logic [1:0] {
    PH_PREFIX, PH_DATA, PH_LSIZE, PH_LSKIP
  } phase_e;

  typedef struct packed {
    logic [7:0] desc_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic               is_field;
    logic [7:0]         field_page;
    logic [15:0]        field_usage;
    logic [15:0]        field_bit_offset;
    logic [7:0]         field_bit_size;
    logic signed [31:0] field_logical_min;
    logic signed [31:0] field_logical_max;
    logic               field_rel;
    logic [7:0]         report_ident;
    logic [5:0]         field_total;
    logic               last_of_run;
  } out_item_t;

  // completed item handed from front to back
  typedef struct packed {
    logic        has_item;
    logic [7:0]  prefix;
    logic [31:0] data;
    logic [2:0]  nbytes;
    logic        last;
  } cmd_t;

endpackage

>>> src/hrfp_front.sv
// ----------------------------------------------------------------------------
// hrfp_front
// Byte framer: collects item prefix and data bytes, skips long items and
// pushes one command per completed item or final byte into the queue.
// ----------------------------------------------------------------------------
module hrfp_front
  import hrfp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  output logic     cmd_valid_o,
  input  logic     cmd_ready_i,
  output cmd_t     cmd_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  prefix_q, prefix_d;
  logic [7:0]  left_q, left_d;
  logic [31:0] accum_q, accum_d;
  logic [2:0]  rcvd_q, rcvd_d;
  logic        fire;
  logic [7:0]  b;
  logic [2:0]  sz;

  assign in_ready_o = cmd_ready_i;
  assign fire       = in_valid_i && cmd_ready_i;
  assign b          = in_item_i.desc_byte;
  assign sz         = (b[1:0] == SizeCode4) ? 3'd4 : {1'b0, b[1:0]};

  // next state of the framer
  always_comb begin
    phase_d  = phase_q;
    prefix_d = prefix_q;
    left_d   = left_q;
    accum_d  = accum_q;
    rcvd_d   = rcvd_q;
    cmd_o    = '0;
    cmd_o.last = in_item_i.last_byte;
    unique case (phase_q)
      PH_PREFIX: begin
        if (b == PfxLong) begin
          phase_d = PH_LSIZE;
        end else if (sz == 3'd0) begin
          cmd_o.has_item = 1'b1;
          cmd_o.prefix   = b;
        end else begin
          prefix_d = b;
          left_d   = {5'd0, sz};
          accum_d  = '0;
          rcvd_d   = '0;
          phase_d  = PH_DATA;
        end
      end
      PH_DATA: begin
        accum_d = accum_q | ({24'd0, b} << {rcvd_q[1:0], 3'b000});
        rcvd_d  = rcvd_q + 3'd1;
        left_d  = left_q - 8'd1;
        if (left_d == 8'd0) begin
          phase_d        = PH_PREFIX;
          cmd_o.has_item = 1'b1;
          cmd_o.prefix   = prefix_q;
          cmd_o.data     = accum_d;
          cmd_o.nbytes   = rcvd_d;
        end
      end
      PH_LSIZE: begin
        left_d  = b;
        phase_d = (b != 8'd0) ? PH_LSKIP : PH_PREFIX;
      end
      PH_LSKIP: begin
        left_d = left_q - 8'd1;
        if (left_d == 8'd0) phase_d = PH_PREFIX;
      end
      default: phase_d = PH_PREFIX;
    endcase
    if (in_item_i.last_byte) begin
      phase_d = PH_PREFIX;
      left_d  = '0;
    end
  end

  assign cmd_valid_o = in_valid_i && (cmd_o.has_item || cmd_o.last);

  // framer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_PREFIX;
      prefix_q <= '0;
      left_q   <= '0;
      accum_q  <= '0;
      rcvd_q   <= '0;
    end else if (fire) begin
      phase_q  <= phase_d;
      prefix_q <= prefix_d;
      left_q   <= left_d;
      accum_q  <= accum_d;
      rcvd_q   <= rcvd_d;
    end
  end

  // a long item skip never starts with a zero count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_LSKIP |-> left_q != 8'd0)
    else $error("long item skip with zero count");
  // data phase holds at most four bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> rcvd_q < 3'd4)
    else $error("data byte count overrun");
  // a pushed command is not empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_o |-> (cmd_o.has_item || cmd_o.last))
    else $error("empty command");

endmodule

>>> src/hrfp_queue.sv
// ----------------------------------------------------------------------------
// hrfp_queue
// Small command queue between front and back.
// ----------------------------------------------------------------------------
module hrfp_queue
  import hrfp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  cmd_t wr_data_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output cmd_t rd_data_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [PtrW:0]   cnt_q;
  logic            push, pop;

  assign wr_ready_o = (cnt_q != QueueDepth[PtrW:0]);
  assign rd_valid_o = (cnt_q != '0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= wr_data_i;
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= (wptr_q == PtrW'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
      if (pop)  rptr_q <= (rptr_q == PtrW'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QueueDepth[PtrW:0])
    else $error("queue count overflow");

endmodule

>>> src/hrfp_back.sv
// ----------------------------------------------------------------------------
// hrfp_back
// Item executor: keeps globals and locals, emits one field record per cycle
// for an Input item unless output stalls, and the summary on the final byte.
// ----------------------------------------------------------------------------
module hrfp_back
  import hrfp_pkg::*;
#(
  parameter int unsigned MaxFields  = MaxFieldsDefault,
  parameter int unsigned UsageSlots = UsageSlotsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [CfgW-1:0] field_cap_i,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  cmd_t            cmd_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_item_t       out_item_o
);

  localparam int unsigned SlotW = (UsageSlots > 1) ? $clog2(UsageSlots) : 1;
  localparam int unsigned FillW = $clog2(UsageSlots + 1);
  localparam int unsigned EmitW = $clog2(MaxFields + 1);

  logic [7:0]        page_q;
  logic [31:0]       lmin_q, lmax_q;
  logic [7:0]        size_q, count_q;
  logic [15:0]       offs_q;
  logic [7:0]        rep_q;
  logic [7:0]        ulist_q [UsageSlots];
  logic [FillW-1:0]  fill_q;
  logic [31:0]       rlow_q, rhigh_q;
  logic              rvalid_q;
  logic [EmitW-1:0]  emitted_q;

  // emission loop
  logic              busy_q;
  logic              use_list_q;
  logic [31:0]       jlim_q, j_q;
  logic [FillW-1:0]  slot_q;
  logic              rel_q;
  logic              last_q;
  logic              sum_q;
  logic [7:0]        rest_q;

  out_item_t         obuf_q;
  logic              ovalid_q;
  logic              ofree;
  logic [EmitW-1:0]  cap;
  logic [31:0]       data;
  logic [31:0]       sext;
  logic [7:0]        cnt_eff;
  logic [31:0]       range_n;
  logic              more;
  logic              take;
  logic              emit_fire;
  logic              sum_fire;
  logic [15:0]       skip_bits;

  assign ofree       = !ovalid_q || out_ready_i;
  assign out_valid_o = ovalid_q;
  assign out_item_o  = obuf_q;
  assign cap = ({2'b0, field_cap_i} < (CfgW+2)'(MaxFields)) ?
               EmitW'(field_cap_i) : EmitW'(MaxFields);
  assign data    = cmd_i.data;
  assign cnt_eff = (count_q != 8'd0) ? count_q : 8'd1;
  assign range_n = rhigh_q - rlow_q + 32'd1;
  assign cmd_ready_o = !busy_q && !sum_q && ofree;
  assign take    = cmd_valid_i && cmd_ready_o;
  assign more    = (j_q < jlim_q) && (emitted_q < cap);
  assign emit_fire = busy_q && ofree && more;
  assign sum_fire  = !busy_q && sum_q && ofree;

  // sign extension by data size
  always_comb begin
    case (cmd_i.nbytes)
      3'd1:    sext = {{24{data[7]}}, data[7:0]};
      3'd2:    sext = {{16{data[15]}}, data[15:0]};
      default: sext = data;
    endcase
  end

  // size * count of the rest that is skipped (16-bit product)
  assign skip_bits = {8'd0, size_q} * {8'd0, rest_q};

  // execution and emission
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q <= '0; lmin_q <= '0; lmax_q <= '0; size_q <= '0; count_q <= '0;
      offs_q <= '0; rep_q <= '0; fill_q <= '0; rlow_q <= '0; rhigh_q <= '0;
      rvalid_q <= 1'b0; emitted_q <= '0; busy_q <= 1'b0; use_list_q <= 1'b0;
      jlim_q <= '0; j_q <= '0; slot_q <= '0; rel_q <= 1'b0; last_q <= 1'b0;
      sum_q <= 1'b0; rest_q <= '0; ovalid_q <= 1'b0; obuf_q <= '0;
    end else begin
      if (emit_fire || sum_fire) ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
      if (busy_q && ofree) begin
        if (more) begin
          obuf_q <= '{is_field: 1'b1, field_page: page_q,
                      field_usage: use_list_q ? {8'd0, ulist_q[slot_q[SlotW-1:0]]}
                                              : 16'(rlow_q + j_q),
                      field_bit_offset: offs_q, field_bit_size: size_q,
                      field_logical_min: lmin_q, field_logical_max: lmax_q,
                      field_rel: rel_q, report_ident: rep_q, field_total: '0,
                      last_of_run: !last_q &&
                        !((j_q + 32'd1 < jlim_q) && (emitted_q + 1'b1 < cap))};
          offs_q    <= offs_q + 16'(size_q);
          emitted_q <= emitted_q + 1'b1;
          j_q       <= j_q + 32'd1;
          slot_q    <= (slot_q + 1'b1 == fill_q) ? '0 : slot_q + 1'b1;
        end else begin
          busy_q <= 1'b0;
          offs_q <= offs_q + skip_bits;
          rest_q <= '0;
          fill_q <= '0;
          rvalid_q <= 1'b0;
          sum_q  <= last_q;
        end
      end else if (sum_q && ofree) begin
        obuf_q <= '{report_ident: rep_q, field_total: 6'(emitted_q),
                    last_of_run: 1'b1, default: '0};
        sum_q <= 1'b0;
        page_q <= '0; lmin_q <= '0; lmax_q <= '0; size_q <= '0; count_q <= '0;
        offs_q <= '0; rep_q <= '0; fill_q <= '0; rlow_q <= '0; rhigh_q <= '0;
        rvalid_q <= 1'b0; emitted_q <= '0;
      end else if (take) begin
        if (cmd_i.has_item) begin
          case (cmd_i.prefix)
            PfxPage: page_q <= data[7:0];
            PfxLmin1, PfxLmin2, PfxLmin4: lmin_q <= sext;
            PfxLmax1, PfxLmax2, PfxLmax4: lmax_q <= sext;
            PfxSize: size_q <= data[7:0];
            PfxReportId: begin
              rep_q  <= data[7:0];
              offs_q <= '0;
            end
            PfxCount: count_q <= data[7:0];
            PfxUsage: begin
              if (fill_q < FillW'(UsageSlots)) begin
                ulist_q[fill_q[SlotW-1:0]] <= data[7:0];
                fill_q <= fill_q + 1'b1;
              end
            end
            PfxUmin1, PfxUmin2, PfxUmin4: begin
              rlow_q <= data; rvalid_q <= 1'b1;
            end
            PfxUmax1, PfxUmax2, PfxUmax4: begin
              rhigh_q <= data; rvalid_q <= 1'b1;
            end
            PfxColl: begin
              fill_q <= '0; rvalid_q <= 1'b0;
            end
            PfxInput: begin
              busy_q <= 1'b1;
              j_q    <= '0;
              slot_q <= '0;
              rel_q  <= data[2];
              if (data[0] || (fill_q == '0 && !rvalid_q)) begin
                jlim_q <= '0;
                rest_q <= cnt_eff;
              end else if (fill_q != '0) begin
                use_list_q <= 1'b1;
                jlim_q <= {24'd0, cnt_eff};
                rest_q <= '0;
              end else begin
                use_list_q <= 1'b0;
                jlim_q <= range_n;
                if ({24'd0, cnt_eff} > range_n) rest_q <= cnt_eff - range_n[7:0];
                else rest_q <= '0;
              end
            end
            default: ;
          endcase
        end
        last_q <= cmd_i.last;
        if (!(cmd_i.has_item && cmd_i.prefix == PfxInput)) sum_q <= cmd_i.last;
      end
    end
  end

  // the emission loop and the summary never run together
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(busy_q && sum_q))
    else $error("emission and summary overlap");
  // field count never passes MaxFields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emitted_q <= EmitW'(MaxFields))
    else $error("field count above limit");
  // no command is taken while a result waits on a stalled receiver
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !out_ready_i |-> !cmd_ready_o)
    else $error("command taken under stall");

endmodule

>>> src/hid_report_field_parser.sv
// ----------------------------------------------------------------------------
// hid_report_field_parser
// HID report descriptor parser that emits one record per report field.
// ----------------------------------------------------------------------------
// Usage: descriptor bytes enter on in_valid_i/in_ready_o, one beat per byte,
// with last_byte set on the final byte. Field records and the closing summary
// leave on out_valid_o/out_ready_i; last_of_run marks the final result of a
// byte. The field cap is written through cfg_we_i/cfg_data_i; the user must
// do so only while idle, the block does not enforce it. A byte is framed in
// the cycle it is accepted and its command passes through the queue to the
// executor, which writes the first record into the output register. Bytes
// that cause no record enter at one byte per cycle while the queue has room;
// an Input item holds the executor while it emits its records and closes the
// loop, and the front stalls once the two-entry command queue fills.
// At reset all parser state clears and the field cap returns to 32. A stalled
// receiver holds the output register, which stops the executor and then,
// through the queue, the byte input.
// ----------------------------------------------------------------------------
module hid_report_field_parser
  import hrfp_pkg::*;
#(
  parameter int unsigned MaxFields  = MaxFieldsDefault,
  parameter int unsigned UsageSlots = UsageSlotsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_item_t        in_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_item_t       out_item_o
);

  logic [CfgW-1:0] field_cap_q;
  logic            f_valid, f_ready, b_valid, b_ready;
  cmd_t            f_cmd, b_cmd;
  logic            q_ready;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) field_cap_q <= CfgW'(MaxFieldsDefault);
    else if (cfg_we_i) field_cap_q <= cfg_data_i;
  end

  assign f_ready = q_ready;

  hrfp_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .cmd_valid_o(f_valid), .cmd_ready_i(f_ready), .cmd_o(f_cmd)
  );

  hrfp_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(f_valid), .wr_ready_o(q_ready), .wr_data_i(f_cmd),
    .rd_valid_o(b_valid), .rd_ready_i(b_ready), .rd_data_o(b_cmd)
  );

  hrfp_back #(.MaxFields(MaxFields), .UsageSlots(UsageSlots)) u_back (
    .clk_i, .rst_ni, .field_cap_i(field_cap_q),
    .cmd_valid_i(b_valid), .cmd_ready_o(b_ready), .cmd_i(b_cmd),
    .out_valid_o, .out_ready_i, .out_item_o
  );

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the HID report field parser. Descriptor bytes are
// driven through the byte channel with random gaps, a local descriptor model
// predicts every field record and summary, and a monitor compares each output
// beat field by field against the oldest predicted record.
// ----------------------------------------------------------------------------
module tb_top;
  import hrfp_pkg::*;

  localparam int unsigned IdleLimit = 20000;

  logic      clk_i;
  logic      rst_ni;
  logic      cfg_we_i;
  logic [CfgW-1:0] cfg_data_i;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  hid_report_field_parser dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  // predicted records, oldest first
  out_item_t records_q[$];
  int unsigned fail_count;
  int unsigned bytes_sent;
  int unsigned records_seen;
  int unsigned idle_cycles;
  bit          idle_enable;

  // descriptor model state
  logic [5:0]  cap_reg;
  phase_e      phase;
  logic [7:0]  pend_prefix;
  logic [7:0]  remain;
  logic [31:0] accum;
  logic [2:0]  got;
  logic [7:0]  page_r;
  logic [31:0] lmin_r;
  logic [31:0] lmax_r;
  logic [7:0]  size_r;
  logic [7:0]  count_r;
  logic [15:0] offset_r;
  logic [7:0]  report_r;
  logic [7:0]  usages[8];
  logic [3:0]  fill_r;
  logic [31:0] ulow_r;
  logic [31:0] uhigh_r;
  logic        urange_r;
  logic [5:0]  emitted_r;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // descriptor model
  // ---------------------------------------------------------------------------
  function automatic void clear_parse();
    phase = PH_PREFIX; pend_prefix = '0; remain = '0; accum = '0; got = '0;
    page_r = '0; lmin_r = '0; lmax_r = '0; size_r = '0; count_r = '0;
    offset_r = '0; report_r = '0; fill_r = '0; ulow_r = '0; uhigh_r = '0;
    urange_r = 1'b0; emitted_r = '0;
    for (int i = 0; i < 8; i++) usages[i] = '0;
  endfunction

  function automatic void push_field(logic [31:0] usage, logic rel);
    out_item_t r;
    r = '0;
    r.is_field = 1'b1;
    r.field_page = page_r;
    r.field_usage = usage[15:0];
    r.field_bit_offset = offset_r;
    r.field_bit_size = size_r;
    r.field_logical_min = lmin_r;
    r.field_logical_max = lmax_r;
    r.field_rel = rel;
    r.report_ident = report_r;
    records_q.push_back(r);
    emitted_r = emitted_r + 6'd1;
    offset_r = offset_r + 16'(size_r);
  endfunction

  function automatic void run_input(logic [7:0] flags);
    int unsigned cap, cnt, span;
    logic rel;
    cap = (cap_reg < MaxFieldsDefault) ? cap_reg : MaxFieldsDefault;
    cnt = (count_r != 0) ? count_r : 1;
    rel = flags[2];
    if (flags[0]) begin
      offset_r = offset_r + 16'(size_r * cnt);
    end else if (fill_r > 0) begin
      for (int unsigned j = 0; j < cnt && emitted_r < cap; j++)
        push_field({24'd0, usages[(j % fill_r) % 8]}, rel);
    end else if (urange_r) begin
      span = uhigh_r - ulow_r + 32'd1;
      for (int unsigned j = 0; j < span && emitted_r < cap; j++)
        push_field(ulow_r + j, rel);
      if (cnt > span) offset_r = offset_r + 16'(size_r * (cnt - span));
    end else begin
      offset_r = offset_r + 16'(size_r * cnt);
    end
    fill_r = '0;
    urange_r = 1'b0;
  endfunction

  function automatic logic [31:0] sext(logic [31:0] v, int unsigned nb);
    if (nb == 1) return {{24{v[7]}}, v[7:0]};
    if (nb == 2) return {{16{v[15]}}, v[15:0]};
    return v;
  endfunction

  function automatic void exec_item(logic [7:0] pfx, logic [31:0] d, int unsigned nb);
    case (pfx)
      PfxPage: page_r = d[7:0];
      PfxLmin1, PfxLmin2, PfxLmin4: lmin_r = sext(d, nb);
      PfxLmax1, PfxLmax2, PfxLmax4: lmax_r = sext(d, nb);
      PfxSize: size_r = d[7:0];
      PfxReportId: begin
        report_r = d[7:0];
        offset_r = '0;
      end
      PfxCount: count_r = d[7:0];
      PfxUsage: begin
        if (fill_r < 8) begin
          usages[fill_r[2:0]] = d[7:0];
          fill_r = fill_r + 4'd1;
        end
      end
      PfxUmin1, PfxUmin2, PfxUmin4: begin
        ulow_r = d;
        urange_r = 1'b1;
      end
      PfxUmax1, PfxUmax2, PfxUmax4: begin
        uhigh_r = d;
        urange_r = 1'b1;
      end
      PfxInput: run_input(d[7:0]);
      PfxColl: begin
        fill_r = '0;
        urange_r = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // predicts the records caused by one descriptor byte
  function automatic void parse_byte(in_item_t it);
    int unsigned n_prior, nb;
    out_item_t s;
    logic [7:0] b;
    n_prior = records_q.size();
    b = it.desc_byte;
    case (phase)
      PH_PREFIX: begin
        if (b == PfxLong) begin
          phase = PH_LSIZE;
        end else begin
          nb = (b[1:0] == SizeCode4) ? 4 : b[1:0];
          if (nb == 0) begin
            exec_item(b, '0, 0);
          end else begin
            pend_prefix = b; remain = 8'(nb); accum = '0; got = '0;
            phase = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        accum = accum | (32'(b) << (8 * got[1:0]));
        got = got + 3'd1;
        remain = remain - 8'd1;
        if (remain == 0) begin
          phase = PH_PREFIX;
          exec_item(pend_prefix, accum, got);
        end
      end
      PH_LSIZE: begin
        remain = b;
        phase = (b != 0) ? PH_LSKIP : PH_PREFIX;
      end
      default: begin
        remain = remain - 8'd1;
        if (remain == 0) phase = PH_PREFIX;
      end
    endcase
    if (it.last_byte) begin
      s = '0;
      s.report_ident = report_r;
      s.field_total = emitted_r;
      records_q.push_back(s);
      clear_parse();
    end
    if (records_q.size() > n_prior) records_q[records_q.size() - 1].last_of_run = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // byte channel driver
  // ---------------------------------------------------------------------------
  // valid stays high between back-to-back beats and drops for a gap or a drain
  task automatic send_byte(logic [7:0] b, logic last);
    in_item_t it;
    int unsigned gap;
    it.desc_byte = b;
    it.last_byte = last;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    parse_byte(it);
    bytes_sent++;
  endtask

  task automatic send_item(logic [7:0] pfx, logic [31:0] d);
    int unsigned nb;
    nb = (pfx[1:0] == SizeCode4) ? 4 : pfx[1:0];
    send_byte(pfx, 1'b0);
    for (int unsigned i = 0; i < nb; i++) send_byte(d[8 * i +: 8], 1'b0);
  endtask

  task automatic end_descriptor();
    send_byte(8'h00, 1'b1);
  endtask

  // waits for all records, then lets trailing work drain before a config write
  task automatic drain();
    in_valid_i <= 1'b0;
    while (records_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cap(logic [5:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cap_reg = v;
  endtask

  // ---------------------------------------------------------------------------
  // test tasks
  // ---------------------------------------------------------------------------
  task automatic test_globals_and_list();
    send_item(PfxPage, 32'h01);
    send_item(PfxLmin1, 32'h80);
    send_item(PfxLmax2, 32'h7FFF);
    send_item(PfxSize, 32'h08);
    send_item(PfxCount, 32'h00);
    send_item(PfxUsage, 32'h30);
    send_item(PfxUsage, 32'hFF);
    send_item(PfxInput, 32'h06);
    send_item(PfxLmin4, 32'h8000_0000);
    send_item(PfxLmax4, 32'h7FFF_FFFF);
    send_item(PfxCount, 32'h05);
    send_item(PfxUsage, 32'h31);
    send_item(PfxUsage, 32'h32);
    send_item(PfxInput, 32'h02);
    end_descriptor();
  endtask

  task automatic test_range_and_const();
    send_item(PfxReportId, 32'hFF);
    send_item(PfxSize, 32'hFF);
    send_item(PfxCount, 32'h06);
    send_item(PfxUmin2, 32'hFFFE);
    send_item(PfxUmax2, 32'hFFFF);
    send_item(PfxInput, 32'h00);
    send_item(PfxUsage, 32'h01);
    send_item(PfxInput, 32'h01);
    send_item(PfxUsage, 32'h01);
    send_item(PfxColl, 32'h01);
    send_item(PfxInput, 32'h00);
    send_item(PfxLmax1, 32'h7F);
    end_descriptor();
  endtask

  task automatic test_long_and_truncated();
    send_byte(PfxLong, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(PfxLong, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h0C, 1'b0);
    send_byte(PfxUmin4, 1'b0);
    send_byte(8'h12, 1'b1);
  endtask

  task automatic test_cap_limits();
    write_cap(6'd0);
    send_item(PfxUsage, 32'h05);
    send_item(PfxInput, 32'h00);
    end_descriptor();
    write_cap(6'd63);
    send_item(PfxSize, 32'h01);
    send_item(PfxCount, 32'hFF);
    send_item(PfxUsage, 32'h07);
    send_item(PfxInput, 32'h00);
    end_descriptor();
    write_cap(6'd1);
    send_item(PfxUmin1, 32'h00);
    send_item(PfxUmax1, 32'h10);
    send_item(PfxInput, 32'h04);
    end_descriptor();
  endtask

  // random item of any form, mostly well-formed items
  task automatic rand_item();
    logic [7:0] pfx;
    logic [7:0] pfx_set[14];
    logic [31:0] d;
    pfx_set = '{PfxPage, PfxLmin1, PfxLmax2, PfxLmin4, PfxSize, PfxReportId,
                PfxCount, PfxUsage, PfxUsage, PfxUmin1, PfxUmax2, PfxUmin4,
                PfxInput, PfxColl};
    d = $urandom();
    case ($urandom_range(0, 19))
      0: send_byte(8'($urandom()), 1'b0);
      1: begin
        send_byte(PfxLong, 1'b0);
        send_byte(8'($urandom_range(0, 3)), 1'b0);
      end
      2, 3, 4: begin
        if ($urandom_range(0, 1)) d = $urandom_range(0, 8);
        send_item(PfxInput, d);
      end
      5: send_item(PfxCount, $urandom_range(0, 12));
      6: send_item(PfxUmax1, d);
      default: begin
        pfx = pfx_set[$urandom_range(0, 13)];
        send_item(pfx, d);
      end
    endcase
  endtask

  task automatic test_random(int unsigned n_bytes);
    int unsigned stop;
    stop = bytes_sent + n_bytes;
    while (bytes_sent < stop) begin
      rand_item();
      if ($urandom_range(0, 24) == 0) end_descriptor();
    end
    end_descriptor();
  endtask

  // ---------------------------------------------------------------------------
  // output monitor and receiver stalls
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      records_seen++;
      if (records_q.size() == 0) begin
        $display("%0t: unexpected record exp=none act=%p", $time, out_item_o);
        fail_count++;
      end else begin
        out_item_t e;
        e = records_q.pop_front();
        if (e.is_field !== out_item_o.is_field ||
            e.field_page !== out_item_o.field_page ||
            e.field_usage !== out_item_o.field_usage ||
            e.field_bit_offset !== out_item_o.field_bit_offset ||
            e.field_bit_size !== out_item_o.field_bit_size ||
            e.field_logical_min !== out_item_o.field_logical_min ||
            e.field_logical_max !== out_item_o.field_logical_max ||
            e.field_rel !== out_item_o.field_rel ||
            e.report_ident !== out_item_o.report_ident ||
            e.field_total !== out_item_o.field_total ||
            e.last_of_run !== out_item_o.last_of_run) begin
          $display("%0t: record mismatch exp=%p act=%p", $time, e, out_item_o);
          fail_count++;
        end
      end
    end
  end

  // receiver stall bursts
  int unsigned stall_left;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= (stall_left == 1);
    end else if (idle_enable && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 10);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    out_ready_i = 1'b1;
    stall_left = 0;
    idle_cycles = 0;
    fail_count = 0;
    bytes_sent = 0;
    records_seen = 0;
    idle_enable = 1'b1;
    cap_reg = 6'd32;
    clear_parse();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_globals_and_list();
    test_range_and_const();
    test_long_and_truncated();
    test_cap_limits();
    write_cap(6'd32);
    test_random(110);
    drain();
    write_cap(6'd5);
    test_random(100);
    idle_enable = 1'b0;
    drain();
    write_cap(6'd32);
    test_random(100);
    drain();

    $display("covered %0d descriptor bytes and %0d output records", bytes_sent,
             records_seen);
    $display("field caps 0, 1, 5, 32 and 63 with list, range, long and cut items");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
